@@ hw/rtl/gcns_pkg.sv @@
// Shared types, codes and constants for the great-circle nearest search.
// Used by gcns_store, gcns_mul and the great_circle_nearest_search top level.
`timescale 1ns / 1ps

package gcns_pkg;

  // Point table size and the index and count widths that follow from it
  localparam int MAX_POINTS = 8192;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Stream field widths
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int TYPE_W       = 4;
  localparam int ANGLE_W      = 32;
  localparam int MATCH_IDX_W  = 13;
  localparam int METRIC_W     = 31;
  localparam int IN_DATA_W    = 72;   // type, lat, lon, filter
  localparam int OUT_DATA_W   = 112;  // index, type, lat, lon, metric

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd3;

  // Q2.30 fixed point
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;  // pi * 2^29
  localparam logic [5:0]  SH_Q30      = 6'd30;

  // Horner divisors as reciprocal multiplies: v / d == (v * M) >> K for v < 2^30.
  // Entries 0..3 serve the cosine series (56, 30, 12, 2), 4..7 the sine series
  // (72, 42, 20, 6).  K is 30 plus ceil(log2(d)).
  localparam logic [31:0] DIV_M [8] = '{
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1)  / 64'd2),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5)  / 64'd6)
  };
  localparam logic [5:0] DIV_K [8] = '{
    6'd36, 6'd35, 6'd34, 6'd31, 6'd37, 6'd36, 6'd35, 6'd33
  };

  // One stored point
  typedef struct packed {
    logic [TYPE_W-1:0]  ptype;
    logic [ANGLE_W-1:0] lat;
    logic [ANGLE_W-1:0] lon;
  } point_t;

  // Operation for the shared multiply-shift unit
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [5:0]  sh;
  } mul_op_t;

  // Octant setup of one sine or cosine evaluation
  typedef struct packed {
    logic [29:0] t;       // reduced angle, at most 2^29
    logic        need_s;  // octant sine wanted, else octant cosine
    logic        neg;     // result sign
  } fn_setup_t;

  // Fold a full binary angle into the first octant and pick series and sign
  function automatic fn_setup_t fn_setup(input logic [31:0] ang, input logic want_cos);
    fn_setup_t   res;
    logic [1:0]  q;
    logic [29:0] r;
    logic [30:0] fold;
    logic        swap;
    logic        pick_sr;
    q       = ang[31:30];
    r       = ang[29:0];
    swap    = (r > 30'h2000_0000);
    fold    = 31'h4000_0000 - {1'b0, r};
    res.t   = swap ? fold[29:0] : r;
    pick_sr = want_cos ? q[0] : ~q[0];
    res.need_s = pick_sr ^ swap;
    res.neg    = want_cos ? ((q == 2'd1) || (q == 2'd2)) : q[1];
    return res;
  endfunction

endpackage

@@ hw/rtl/gcns_store.sv @@
// Point table: one write port for appends, one registered read port for scans.
// Depends on gcns_pkg for the table depth and the point layout.
`timescale 1ns / 1ps

module gcns_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [gcns_pkg::IDX_W-1:0]     waddr_i,
  input  gcns_pkg::point_t               wdata_i,
  input  logic                           re_i,
  input  logic [gcns_pkg::IDX_W-1:0]     raddr_i,
  output gcns_pkg::point_t               rdata_o
);

  gcns_pkg::point_t mem_q [gcns_pkg::MAX_POINTS];
  gcns_pkg::point_t rdata_q;

  // Write an appended point
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gcns_mul.sv @@
// Shared 32x32 multiplier with a right shift and a result register.
// Depends on gcns_pkg for the operation struct.
`timescale 1ns / 1ps

module gcns_mul (
  input  logic              clk_i,
  input  gcns_pkg::mul_op_t op_i,
  output logic [31:0]       res_o
);

  logic [63:0] prod;
  logic [31:0] res_d;
  logic [31:0] res_q;

  // Multiply, then scale down by the requested shift
  assign prod  = 64'(op_i.a) * 64'(op_i.b);
  assign res_d = 32'(prod >> op_i.sh);

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/great_circle_nearest_search.sv @@
// Great-circle nearest search: point table with a haversine nearest query.
// Uses gcns_pkg, gcns_store (point table) and gcns_mul (shared multiplier).
//
// Usage: each input word on the s_axis side carries a request in tuser
// (append, query, clear) and point type, latitude, longitude and type filter
// in tdata. Every request gives exactly one result word on the m_axis side:
// status in tuser, and index, type, latitude, longitude and haversine term of
// the winning point in tdata (all zero unless a match was found).
// A query first evaluates cos(lat) of the query point, then scans the table
// in index order, skipping points the filter drops. Each point it passes
// takes three sine/cosine series of 9 or 10 steps, each step a pass through
// the single multiplier, plus 4 more multiplies for the squares and products.
// The block takes one request at a time; tready is high only while idle.
// A finished result sits in the output register until taken; the block
// may accept the next request meanwhile and stalls before its own result.
// Reset empties the table (count zero) and drops any pending result.
`timescale 1ns / 1ps

module great_circle_nearest_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [3:0] point_type, [35:4] lat_angle, [67:36] lon_angle, [71:68] type_filter
  input  logic [gcns_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [1:0] req_type
  input  logic [gcns_pkg::REQ_W-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [12:0] match_index, [16:13] match_type, [48:17] match_lat,
  // [80:49] match_lon, [111:81] match_metric
  output logic [gcns_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [1:0] status
  output logic [gcns_pkg::STATUS_W-1:0]     m_axis_tuser_o
);

  localparam int IDX_W = gcns_pkg::IDX_W;
  localparam int CNT_W = gcns_pkg::CNT_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP   = 3'd1;
  localparam logic [2:0] ST_FN   = 3'd2;
  localparam logic [2:0] ST_MW   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WT   = 3'd5;
  localparam logic [2:0] ST_PUT  = 3'd6;

  // Per-point operation steps
  localparam logic [2:0] PS_SA  = 3'd0;  // sin(dlat/2)
  localparam logic [2:0] PS_SA2 = 3'd1;  // square it
  localparam logic [2:0] PS_SB  = 3'd2;  // sin(dlon/2)
  localparam logic [2:0] PS_SB2 = 3'd3;  // square it
  localparam logic [2:0] PS_C2  = 3'd4;  // cos(lat2)
  localparam logic [2:0] PS_PM  = 3'd5;  // cos product
  localparam logic [2:0] PS_H   = 3'd6;  // weighted term and compare
  localparam logic [2:0] PS_C1  = 3'd7;  // cos(lat1), once per query

  localparam logic [3:0] STEP_X    = 4'd0;
  localparam logic [3:0] STEP_Z    = 4'd1;
  localparam logic [3:0] STEP_SIN  = 4'd9;
  localparam logic [3:0] STEP_COS  = 4'd8;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [31:0]             lat_q, lat_d, lon_q, lon_d;
  logic [3:0]              filt_q, filt_d;
  logic [1:0]              status_q, status_d;
  logic [2:0]              pstep_q, pstep_d;
  logic [3:0]              step_q, step_d;
  logic                    phase_q, phase_d;
  logic [29:0]             t_q, t_d;
  logic                    need_s_q, need_s_d;
  logic                    fneg_q, fneg_d;
  logic [31:0]             x_q, x_d, z_q, z_d, acc_q, acc_d;
  logic [31:0]             c1_q, c1_d;
  logic                    c1neg_q, c1neg_d;
  logic [31:0]             sa2_q, sa2_d, sb2_q, sb2_d, pm_q, pm_d;
  logic                    found_q, found_d;
  logic [30:0]             best_h_q, best_h_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  gcns_pkg::point_t        best_pt_q, best_pt_d;
  logic                    m_valid_q, m_valid_d;
  logic [1:0]              m_user_q, m_user_d;
  logic [gcns_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  gcns_pkg::mul_op_t       mop;
  logic [31:0]             mres;
  gcns_pkg::point_t        wdata;
  gcns_pkg::point_t        rdata;
  logic                    we;
  logic                    re;
  gcns_pkg::fn_setup_t     fset;
  logic [31:0]             fn_ang;
  logic                    fn_cos;
  logic [31:0]             dlat, dlon;
  logic [2:0]              div_sel;
  logic [3:0]              last_step;
  logic [31:0]             acc_next;
  logic signed [33:0]      h_raw;
  logic [30:0]             h_val;
  logic                    better;
  logic                    last_pt;
  logic                    filt_pass;

  // Input word fields
  assign wdata.ptype = s_axis_tdata_i[3:0];
  assign wdata.lat   = s_axis_tdata_i[35:4];
  assign wdata.lon   = s_axis_tdata_i[67:36];

  gcns_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  gcns_mul u_mul (
    .clk_i (clk_i),
    .op_i  (mop),
    .res_o (mres)
  );

  // Angle differences to the stored point, wrapping mod 2^32
  assign dlat = rdata.lat - lat_q;
  assign dlon = rdata.lon - lon_q;

  // Pick the angle for the next series evaluation
  always_comb begin
    case (pstep_q)
      PS_SA: begin
        fn_ang = {1'b0, dlat[31:1]};
        fn_cos = 1'b0;
      end
      PS_SB: begin
        fn_ang = {1'b0, dlon[31:1]};
        fn_cos = 1'b0;
      end
      PS_C2: begin
        fn_ang = rdata.lat;
        fn_cos = 1'b1;
      end
      default: begin
        fn_ang = lat_q;
        fn_cos = 1'b1;
      end
    endcase
  end

  assign fset      = gcns_pkg::fn_setup(fn_ang, fn_cos);
  assign div_sel   = {need_s_q, 2'(step_q[3:1] - 3'd1)};
  assign last_step = need_s_q ? STEP_SIN : STEP_COS;

  // Drive the shared multiplier
  always_comb begin
    mop    = '0;
    mop.sh = gcns_pkg::SH_Q30;
    if (state_q == ST_OP) begin
      case (pstep_q)
        PS_SA2, PS_SB2: begin
          mop.a = acc_q;
          mop.b = acc_q;
        end
        PS_PM: begin
          mop.a = c1_q;
          mop.b = acc_q;
        end
        PS_H: begin
          mop.a = pm_q;
          mop.b = sb2_q;
        end
        default: begin
          mop.a = '0;
        end
      endcase
    end else if (state_q == ST_FN) begin
      case (step_q)
        STEP_X: begin
          mop.a = 32'(t_q);
          mop.b = gcns_pkg::HALF_PI_Q30;
        end
        STEP_Z: begin
          mop.a = x_q;
          mop.b = x_q;
        end
        4'd2: begin
          mop.a  = z_q;
          mop.b  = gcns_pkg::DIV_M[div_sel];
          mop.sh = gcns_pkg::DIV_K[div_sel];
        end
        STEP_SIN: begin
          mop.a = x_q;
          mop.b = acc_q;
        end
        default: begin
          if (step_q[0]) begin
            mop.a = z_q;
            mop.b = acc_q;
          end else begin
            mop.a  = acc_q;
            mop.b  = gcns_pkg::DIV_M[div_sel];
            mop.sh = gcns_pkg::DIV_K[div_sel];
          end
        end
      endcase
    end
  end

  // Series accumulator update: divide steps subtract from one
  assign acc_next = (step_q[0] || step_q == STEP_SIN) ? mres : (gcns_pkg::ONE_Q30 - mres);

  // Haversine term: sa2 plus or minus the weighted product, clamped to [0, 1]
  always_comb begin
    if (c1neg_q ^ fneg_q) begin
      h_raw = $signed({2'b00, sa2_q}) - $signed({2'b00, mres});
    end else begin
      h_raw = $signed({2'b00, sa2_q}) + $signed({2'b00, mres});
    end
    if (h_raw < 0) begin
      h_val = '0;
    end else if (h_raw > $signed({2'b00, gcns_pkg::ONE_Q30})) begin
      h_val = 31'(gcns_pkg::ONE_Q30);
    end else begin
      h_val = h_raw[30:0];
    end
  end

  assign better    = !found_q || (h_val < best_h_q);
  assign last_pt   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign filt_pass = (filt_q == '0) || (rdata.ptype == filt_q);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    filt_d     = filt_q;
    status_d   = status_q;
    pstep_d    = pstep_q;
    step_d     = step_q;
    phase_d    = phase_q;
    t_d        = t_q;
    need_s_d   = need_s_q;
    fneg_d     = fneg_q;
    x_d        = x_q;
    z_d        = z_q;
    acc_d      = acc_q;
    c1_d       = c1_q;
    c1neg_d    = c1neg_q;
    sa2_d      = sa2_q;
    sb2_d      = sb2_q;
    pm_d       = pm_q;
    found_d    = found_q;
    best_h_d   = best_h_q;
    best_idx_d = best_idx_q;
    best_pt_d  = best_pt_q;
    m_valid_d  = m_valid_q;
    m_user_d   = m_user_q;
    m_data_d   = m_data_q;
    we         = 1'b0;
    re         = 1'b0;

    // Drop the output word once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d  = ST_PUT;
          status_d = gcns_pkg::STAT_DONE;
          case (s_axis_tuser_i)
            gcns_pkg::REQ_APPEND: begin
              if (count_q == CNT_W'(gcns_pkg::MAX_POINTS)) begin
                status_d = gcns_pkg::STAT_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            gcns_pkg::REQ_QUERY: begin
              lat_d   = s_axis_tdata_i[35:4];
              lon_d   = s_axis_tdata_i[67:36];
              filt_d  = s_axis_tdata_i[71:68];
              found_d = 1'b0;
              pstep_d = PS_C1;
              state_d = ST_OP;
            end
            gcns_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
              status_d = gcns_pkg::STAT_DONE;
            end
          endcase
        end
      end

      // Start a series evaluation or issue a multiply
      ST_OP: begin
        case (pstep_q)
          PS_SA, PS_SB, PS_C2, PS_C1: begin
            t_d      = fset.t;
            need_s_d = fset.need_s;
            fneg_d   = fset.neg;
            step_d   = STEP_X;
            phase_d  = 1'b0;
            state_d  = ST_FN;
          end
          default: begin
            state_d = ST_MW;
          end
        endcase
      end

      // Series steps: issue, then capture
      ST_FN: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          case (step_q)
            STEP_X:  x_d = mres;
            STEP_Z:  z_d = mres;
            default: acc_d = acc_next;
          endcase
          if (step_q == last_step) begin
            if (pstep_q == PS_C1) begin
              c1_d    = acc_next;
              c1neg_d = fneg_q;
              pstep_d = PS_SA;
              if (count_q == '0) begin
                status_d = gcns_pkg::STAT_NONE;
                state_d  = ST_PUT;
              end else begin
                idx_d   = '0;
                state_d = ST_RD;
              end
            end else begin
              pstep_d = pstep_q + 3'd1;
              state_d = ST_OP;
            end
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end

      // Capture a multiply result
      ST_MW: begin
        case (pstep_q)
          PS_SA2: begin
            sa2_d   = mres;
            pstep_d = PS_SB;
            state_d = ST_OP;
          end
          PS_SB2: begin
            sb2_d   = mres;
            pstep_d = PS_C2;
            state_d = ST_OP;
          end
          PS_PM: begin
            pm_d    = mres;
            pstep_d = PS_H;
            state_d = ST_OP;
          end
          default: begin
            // Keep the strictly smaller term; earlier index wins a tie
            if (better) begin
              found_d    = 1'b1;
              best_h_d   = h_val;
              best_idx_d = idx_q;
              best_pt_d  = rdata;
            end
            if (last_pt) begin
              status_d = gcns_pkg::STAT_MATCH;
              state_d  = ST_PUT;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              state_d = ST_RD;
            end
          end
        endcase
      end

      ST_RD: begin
        re      = 1'b1;
        state_d = ST_WT;
      end

      // Filter the point just read, or move on
      ST_WT: begin
        if (filt_pass) begin
          pstep_d = PS_SA;
          state_d = ST_OP;
        end else if (last_pt) begin
          status_d = found_q ? gcns_pkg::STAT_MATCH : gcns_pkg::STAT_NONE;
          state_d  = ST_PUT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_RD;
        end
      end

      // Hand the result to the output register when it is free
      ST_PUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          if (status_q == gcns_pkg::STAT_MATCH) begin
            m_data_d = {best_h_q, best_pt_q.lon, best_pt_q.lat, best_pt_q.ptype,
                        13'(best_idx_q)};
          end else begin
            m_data_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      lat_q      <= '0;
      lon_q      <= '0;
      filt_q     <= '0;
      status_q   <= gcns_pkg::STAT_DONE;
      pstep_q    <= PS_SA;
      step_q     <= STEP_X;
      phase_q    <= 1'b0;
      t_q        <= '0;
      need_s_q   <= 1'b0;
      fneg_q     <= 1'b0;
      x_q        <= '0;
      z_q        <= '0;
      acc_q      <= '0;
      c1_q       <= '0;
      c1neg_q    <= 1'b0;
      sa2_q      <= '0;
      sb2_q      <= '0;
      pm_q       <= '0;
      found_q    <= 1'b0;
      best_h_q   <= '0;
      best_idx_q <= '0;
      best_pt_q  <= '0;
      m_valid_q  <= 1'b0;
      m_user_q   <= '0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      lat_q      <= lat_d;
      lon_q      <= lon_d;
      filt_q     <= filt_d;
      status_q   <= status_d;
      pstep_q    <= pstep_d;
      step_q     <= step_d;
      phase_q    <= phase_d;
      t_q        <= t_d;
      need_s_q   <= need_s_d;
      fneg_q     <= fneg_d;
      x_q        <= x_d;
      z_q        <= z_d;
      acc_q      <= acc_d;
      c1_q       <= c1_d;
      c1neg_q    <= c1neg_d;
      sa2_q      <= sa2_d;
      sb2_q      <= sb2_d;
      pm_q       <= pm_d;
      found_q    <= found_d;
      best_h_q   <= best_h_d;
      best_idx_q <= best_idx_d;
      best_pt_q  <= best_pt_d;
      m_valid_q  <= m_valid_d;
      m_user_q   <= m_user_d;
      m_data_q   <= m_data_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

@@ tb/sv/great_circle_nearest_search_tb.sv @@
// Testbench for great_circle_nearest_search: streams append, query and clear
// requests, predicts each result word in fixed point and checks it. Uses gcns_pkg.
`timescale 1ns / 1ps

module great_circle_nearest_search_tb;

  localparam int LIMIT_CYCLES = 3000000;

  // Request code that the block ignores
  localparam logic [gcns_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef struct {
    logic [gcns_pkg::REQ_W-1:0]   req;
    logic [gcns_pkg::TYPE_W-1:0]  ptype;
    logic [gcns_pkg::ANGLE_W-1:0] lat;
    logic [gcns_pkg::ANGLE_W-1:0] lon;
    logic [gcns_pkg::TYPE_W-1:0]  filt;
  } request_t;

  typedef struct {
    logic [gcns_pkg::STATUS_W-1:0]    status;
    logic [gcns_pkg::MATCH_IDX_W-1:0] idx;
    logic [gcns_pkg::TYPE_W-1:0]      ptype;
    logic [gcns_pkg::ANGLE_W-1:0]     lat;
    logic [gcns_pkg::ANGLE_W-1:0]     lon;
    logic [gcns_pkg::METRIC_W-1:0]    metric;
  } answer_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [gcns_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [gcns_pkg::REQ_W-1:0]      s_axis_tuser_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [gcns_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [gcns_pkg::STATUS_W-1:0]   m_axis_tuser_o;

  great_circle_nearest_search i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       failed = 1'b0;
  bit       word_taken = 1'b0;
  int       cycle_count = 0;

  // Shadow copy of the point table
  logic [gcns_pkg::TYPE_W-1:0]  tbl_type [gcns_pkg::MAX_POINTS];
  logic [gcns_pkg::ANGLE_W-1:0] tbl_lat  [gcns_pkg::MAX_POINTS];
  logic [gcns_pkg::ANGLE_W-1:0] tbl_lon  [gcns_pkg::MAX_POINTS];
  int                           tbl_count = 0;

  // Series sine and cosine of an angle in the first octant, Q2.30
  function automatic void octant_sin_cos(input longint unsigned t,
                                         output longint unsigned s_o,
                                         output longint unsigned c_o);
    longint unsigned one, x, z, c, s;
    one = 64'd1 << 30;
    x = (t * 64'd1686629713) >> 30;
    z = (x * x) >> 30;
    c = one - z / 56;
    c = one - ((z * c) >> 30) / 30;
    c = one - ((z * c) >> 30) / 12;
    c = one - ((z * c) >> 30) / 2;
    s = one - z / 72;
    s = one - ((z * s) >> 30) / 42;
    s = one - ((z * s) >> 30) / 20;
    s = one - ((z * s) >> 30) / 6;
    s_o = (x * s) >> 30;
    c_o = c;
  endfunction

  // Signed sine and cosine of a full binary angle
  function automatic void bam_sin_cos(input logic [31:0] a, output longint s_o,
                                      output longint c_o);
    longint unsigned su, cu;
    longint sr, cr;
    logic [29:0] r;
    r = a[29:0];
    if (r <= 30'h2000_0000) begin
      octant_sin_cos(r, su, cu);
      sr = su;
      cr = cu;
    end else begin
      octant_sin_cos(64'h4000_0000 - r, su, cu);
      sr = cu;
      cr = su;
    end
    case (a[31:30])
      2'd0: begin s_o = sr;  c_o = cr;  end
      2'd1: begin s_o = cr;  c_o = -sr; end
      2'd2: begin s_o = -sr; c_o = -cr; end
      default: begin s_o = -cr; c_o = sr; end
    endcase
  endfunction

  function automatic longint half_sin_squared(input logic [31:0] d);
    longint s, c;
    bam_sin_cos({1'b0, d[31:1]}, s, c);
    return (s * s) / 64'sd1073741824;
  endfunction

  function automatic longint bam_cos(input logic [31:0] a);
    longint s, c;
    bam_sin_cos(a, s, c);
    return c;
  endfunction

  // Apply one request to the shadow table and give the expected answer
  function automatic answer_t nearest_search_answer(input request_t rq);
    answer_t ans;
    longint  c1, h, best_h, p;
    int      best;
    bit      found;
    ans = '{default: '0};
    case (rq.req)
      gcns_pkg::REQ_APPEND: begin
        if (tbl_count >= gcns_pkg::MAX_POINTS) ans.status = gcns_pkg::STAT_FULL;
        else begin
          tbl_type[tbl_count] = rq.ptype;
          tbl_lat[tbl_count]  = rq.lat;
          tbl_lon[tbl_count]  = rq.lon;
          tbl_count++;
        end
      end
      gcns_pkg::REQ_CLEAR: tbl_count = 0;
      gcns_pkg::REQ_QUERY: begin
        found = 1'b0;
        best = 0;
        best_h = 0;
        c1 = bam_cos(rq.lat);
        for (int i = 0; i < tbl_count; i++) begin
          if (rq.filt != 0 && tbl_type[i] != rq.filt) continue;
          p = (c1 * bam_cos(tbl_lat[i])) / 64'sd1073741824;
          h = half_sin_squared(tbl_lat[i] - rq.lat)
              + (p * half_sin_squared(tbl_lon[i] - rq.lon)) / 64'sd1073741824;
          if (h < 0) h = 0;
          if (h > 64'sd1073741824) h = 64'sd1073741824;
          if (!found || h < best_h) begin
            found = 1'b1;
            best_h = h;
            best = i;
          end
        end
        if (found) begin
          ans.status = gcns_pkg::STAT_MATCH;
          ans.idx    = best[gcns_pkg::MATCH_IDX_W-1:0];
          ans.ptype  = tbl_type[best];
          ans.lat    = tbl_lat[best];
          ans.lon    = tbl_lon[best];
          ans.metric = best_h[gcns_pkg::METRIC_W-1:0];
        end else begin
          ans.status = gcns_pkg::STAT_NONE;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Drive the next request word at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || word_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tuser_i  <= pending_reqs[0].req;
          s_axis_tdata_i  <= {pending_reqs[0].filt, pending_reqs[0].lon,
                              pending_reqs[0].lat, pending_reqs[0].ptype};
          s_axis_tvalid_i <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    answer_t exp_a, got;
    request_t rq;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
    word_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (word_taken) begin
      rq.req   = s_axis_tuser_i;
      rq.ptype = s_axis_tdata_i[3:0];
      rq.lat   = s_axis_tdata_i[35:4];
      rq.lon   = s_axis_tdata_i[67:36];
      rq.filt  = s_axis_tdata_i[71:68];
      expected_answers.push_back(nearest_search_answer(rq));
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tuser_o;
      got.idx    = m_axis_tdata_o[12:0];
      got.ptype  = m_axis_tdata_o[16:13];
      got.lat    = m_axis_tdata_o[48:17];
      got.lon    = m_axis_tdata_o[80:49];
      got.metric = m_axis_tdata_o[111:81];
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, got);
        failed = 1'b1;
      end else begin
        exp_a = expected_answers.pop_front();
        if (got.status !== exp_a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status, got.status);
          failed = 1'b1;
        end
        if (got.idx !== exp_a.idx) begin
          $display("%0t: match_index expected %0d actual %0d", $time, exp_a.idx, got.idx);
          failed = 1'b1;
        end
        if (got.ptype !== exp_a.ptype) begin
          $display("%0t: match_type expected %0d actual %0d", $time, exp_a.ptype, got.ptype);
          failed = 1'b1;
        end
        if (got.lat !== exp_a.lat) begin
          $display("%0t: match_lat expected %h actual %h", $time, exp_a.lat, got.lat);
          failed = 1'b1;
        end
        if (got.lon !== exp_a.lon) begin
          $display("%0t: match_lon expected %h actual %h", $time, exp_a.lon, got.lon);
          failed = 1'b1;
        end
        if (got.metric !== exp_a.metric) begin
          $display("%0t: match_metric expected %0d actual %0d", $time, exp_a.metric,
                   got.metric);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic push_req(input logic [gcns_pkg::REQ_W-1:0] req,
                          input logic [gcns_pkg::TYPE_W-1:0] pt,
                          input logic [31:0] lat, input logic [31:0] lon,
                          input logic [gcns_pkg::TYPE_W-1:0] filt);
    request_t rq;
    rq.req = req;
    rq.ptype = pt;
    rq.lat = lat;
    rq.lon = lon;
    rq.filt = filt;
    pending_reqs.push_back(rq);
  endtask

  // Mostly legal latitudes, sometimes any wrapping angle
  function automatic logic [31:0] rand_lat();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(32'h8000_0000) - 32'sh4000_0000);
  endfunction

  // Wait until every word is sent and every result checked
  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid_i && expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  // Random sessions: clear, fill a small table, query it
  task automatic random_sessions(input int n_items);
    int sent, n_pts;
    logic [31:0] la, lo;
    sent = 0;
    while (sent < n_items) begin
      push_req(gcns_pkg::REQ_CLEAR, 4'($urandom), $urandom, $urandom, 4'($urandom));
      n_pts = $urandom_range(10);
      sent += 1 + n_pts;
      for (int i = 0; i < n_pts; i++) begin
        if (i > 0 && $urandom_range(4) == 0) begin
          push_req(gcns_pkg::REQ_APPEND, pending_reqs[$].ptype, pending_reqs[$].lat,
                   pending_reqs[$].lon, 4'($urandom));
        end else begin
          push_req(gcns_pkg::REQ_APPEND, 4'($urandom_range(3)), rand_lat(), $urandom,
                   4'($urandom));
        end
      end
      repeat ($urandom_range(1, 4)) begin
        la = rand_lat();
        lo = $urandom;
        if ($urandom_range(3) == 0) push_req(REQ_SPARE, 4'($urandom), la, lo, 4'($urandom));
        else push_req(gcns_pkg::REQ_QUERY, 4'($urandom), la, lo,
                      ($urandom_range(2) == 0) ? 4'($urandom) : 4'($urandom_range(3)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles little, receiver mostly stalls; directed cases first
    send_idle_pct = 12;
    recv_idle_pct = 81;
    push_req(gcns_pkg::REQ_QUERY, 4'hF, 32'h0, 32'h0, 4'h0);                // empty table
    push_req(gcns_pkg::REQ_APPEND, 4'h0, 32'h4000_0000, 32'h7FFF_FFFF, 4'hF); // north pole
    push_req(gcns_pkg::REQ_APPEND, 4'hF, 32'hC000_0000, 32'h8000_0000, 4'h0); // south pole
    push_req(gcns_pkg::REQ_APPEND, 4'h5, 32'h0, 32'h0, 4'h0);
    push_req(gcns_pkg::REQ_APPEND, 4'h5, 32'h0, 32'h0, 4'h0);          // tie with previous
    push_req(gcns_pkg::REQ_APPEND, 4'hA, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'h0); // wrapping lat
    push_req(gcns_pkg::REQ_APPEND, 4'h3, 32'h8000_0000, 32'h4000_0000, 4'h0);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h0, 32'h0, 4'h0);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h4000_0000, 32'h0, 4'h0);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'hC000_0000, 32'h8000_0000, 4'hF);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h1234_5678, 32'h8765_4321, 4'h5);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h0, 32'h0, 4'h7);           // filter passes none
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h8000_0000, 32'hFFFF_FFFF, 4'hA);
    push_req(REQ_SPARE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);      // unused code
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h2000_0000, 32'h6000_0000, 4'h3);
    push_req(gcns_pkg::REQ_CLEAR, 4'h0, 32'h0, 32'h0, 4'h0);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h0, 32'h0, 4'h0);
    random_sessions(25);
    wait_drained();

    send_idle_pct = 81;
    recv_idle_pct = 12;
    random_sessions(25);
    wait_drained();

    // No idling: random sessions, then a short directed tail
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sessions(25);
    push_req(gcns_pkg::REQ_CLEAR, 4'h0, 32'h0, 32'h0, 4'h0);
    push_req(gcns_pkg::REQ_APPEND, 4'h9, 32'h1, 32'h1, 4'h0);
    push_req(gcns_pkg::REQ_QUERY, 4'h0, 32'h0, 32'h0, 4'h0);
    wait_drained();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
